// ----- src/tope_pkg.sv -----
// Shared types and constants for the TCP pacing-option extractor.
`default_nettype none

package tope_pkg;

	localparam int MAX_OPTION_BYTES = 40;
	localparam int BL_W             = 6;
	localparam int SK_W             = 8;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 11;
	localparam int CYC_W            = 18;
	localparam int PROD_W           = 19;

	localparam logic [7:0]  PACE_KIND_RST = 8'd253;
	localparam logic [10:0] CYC_PER_US_RST = 11'd633;
	localparam logic [3:0]  HDR_BASE_WORDS = 4'd5;
	localparam logic [7:0]  PACE_SKIP_BYTES = 8'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PACE_KIND = 1'b0,
		CFG_CYC_PER_US = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_KIND = 3'd1,
		PH_SIZE = 3'd2,
		PH_SKIP = 3'd3,
		PH_PACE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		OC_FOUND     = 3'd0,
		OC_EOL       = 3'd1,
		OC_EXHAUSTED = 3'd2,
		OC_TRUNC     = 3'd3,
		OC_SILLY     = 3'd4,
		OC_PARTIAL   = 3'd5,
		OC_NOOPT     = 3'd6
	} outcome_t;

	// Walk end report from the parser to the result stage.
	typedef struct packed {
		logic       done;
		outcome_t   outcome;
		logic [7:0] value;
	} walk_res_t;

endpackage

`default_nettype wire

// ----- src/tope_if.sv -----
// Stream interfaces for option-byte beats and result beats.
`default_nettype none

interface tope_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] opt_byte;
	logic       first_byte;
	logic [3:0] data_offset;

	modport source (output valid, output opt_byte, output first_byte, output data_offset,
		input ready);
	modport sink (input valid, input opt_byte, input first_byte, input data_offset,
		output ready);
endinterface

interface tope_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  outcome;
	logic        found;
	logic [7:0]  pace_value;
	logic [17:0] pace_cycles;

	modport source (output valid, output outcome, output found, output pace_value,
		output pace_cycles, input ready);
	modport sink (input valid, input outcome, input found, input pace_value,
		input pace_cycles, output ready);
endinterface

`default_nettype wire

// ----- src/tcp_option_pace_extractor.sv -----
// Top level: TCP option-area walker that extracts the pacing delay.
//
//  channel     dir  handshake        payload
//  byte_ch     in   valid/ready      opt_byte, first_byte, data_offset
//  result_ch   out  valid/ready      outcome, found, pace_value, pace_cycles
//  cfg         in   cfg_we only      cfg_index, cfg_wdata
//
// One byte beat per cycle, sustained while the result side is not stalled. The walker
// and the multiply-saturate work on the input register in the cycle after a byte is
// taken, and a walk that ends on that byte then loads its result beat into the output register.
// Reset clears the walker to idle and loads the default pace kind and
// cycles-per-microsecond. A stalled result holds the input register, which
// in turn drops byte_ch.ready; nothing is dropped or repeated.
`default_nettype none

module tcp_option_pace_extractor (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [tope_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [tope_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	tope_byte_if.sink                         byte_ch,
	tope_result_if.source                     result_ch
);
	import tope_pkg::*;

	// configuration
	logic [7:0]  pace_kind_q;
	logic [10:0] cyc_per_us_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pace_kind_q  <= PACE_KIND_RST;
			cyc_per_us_q <= CYC_PER_US_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PACE_KIND:  pace_kind_q  <= cfg_wdata[7:0];
				CFG_CYC_PER_US: cyc_per_us_q <= cfg_wdata;
				default:        pace_kind_q  <= pace_kind_q;
			endcase
		end
	end

	// input register
	logic       v_s1;
	logic [7:0] opt_s1;
	logic       first_s1;
	logic [3:0] off_s1;
	logic       out_free;
	logic       adv;
	logic       take;
	walk_res_t  res;

	// the stage advances when the result register can take whatever it makes
	assign adv           = v_s1 && out_free;
	assign byte_ch.ready = !v_s1 || out_free;
	assign take          = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opt_s1   <= byte_ch.opt_byte;
			first_s1 <= byte_ch.first_byte;
			off_s1   <= byte_ch.data_offset;
		end
	end

	// walker: state moves once per beat leaving the input register
	tope_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.opt_byte    (opt_s1),
		.first_byte  (first_s1),
		.data_offset (off_s1),
		.pace_kind   (pace_kind_q),
		.res         (res)
	);

	// result beat only when the walk ends on this byte
	tope_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && res.done),
		.res           (res),
		.cycles_per_us (cyc_per_us_q),
		.free          (out_free),
		.result_ch     (result_ch)
	);

endmodule

`default_nettype wire

// ----- src/tope_parser.sv -----
// Option-list walker: parse state registers and next-state logic for one byte.
`default_nettype none

module tope_parser (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  wire  [7:0]            opt_byte,
	input  wire                   first_byte,
	input  wire  [3:0]            data_offset,
	input  wire  [7:0]            pace_kind,
	output tope_pkg::walk_res_t   res
);
	import tope_pkg::*;

	phase_t          ph_q, ph_n, ph_e;
	logic [BL_W-1:0] bl_q, bl_n, bl_e, bl_dec, len;
	logic [SK_W-1:0] sk_q, sk_n, sk_e;
	logic [7:0]      kind_q, kind_n;
	logic [3:0]      words;
	logic            done;
	outcome_t        oc;
	logic [7:0]      val;

	assign words  = data_offset - HDR_BASE_WORDS;
	assign bl_dec = bl_e - BL_W'(1);

	always_comb begin
		len = (data_offset > HDR_BASE_WORDS) ? {words, 2'b00} : '0;
		if (len > BL_W'(MAX_OPTION_BYTES)) begin
			len = BL_W'(MAX_OPTION_BYTES);
		end
	end

	always_comb begin
		done   = 1'b0;
		oc     = OC_NOOPT;
		val    = '0;
		ph_e   = ph_q;
		bl_e   = bl_q;
		sk_e   = sk_q;
		kind_n = kind_q;
		if (first_byte) begin
			ph_e = PH_KIND;
			bl_e = len;
			sk_e = '0;
		end
		ph_n = ph_e;
		bl_n = bl_e;
		sk_n = sk_e;
		if (first_byte && len == '0) begin
			done = 1'b1;
			oc   = OC_NOOPT;
		end else begin
			case (ph_e)
				PH_KIND: begin
					if (opt_byte == 8'd0) begin
						done = 1'b1;
						oc   = OC_EOL;
					end else if (opt_byte == 8'd1) begin
						bl_n = bl_dec;
						if (bl_dec == '0) begin
							done = 1'b1;
							oc   = OC_EXHAUSTED;
						end
					end else if (bl_e < BL_W'(2)) begin
						done = 1'b1;
						oc   = OC_TRUNC;
					end else begin
						kind_n = opt_byte;
						bl_n   = bl_dec;
						ph_n   = PH_SIZE;
					end
				end
				PH_SIZE: begin
					if (opt_byte < 8'd2) begin
						done = 1'b1;
						oc   = OC_SILLY;
					end else if ({1'b0, opt_byte} > ({3'b000, bl_e} + 9'd1)) begin
						done = 1'b1;
						oc   = OC_PARTIAL;
					end else begin
						bl_n = bl_dec;
						if (kind_q == pace_kind) begin
							if (bl_dec == '0) begin
								done = 1'b1;
								oc   = OC_TRUNC;
							end else begin
								sk_n = PACE_SKIP_BYTES;
								ph_n = PH_PACE;
							end
						end else begin
							sk_n = opt_byte - 8'd2;
							if (opt_byte == 8'd2) begin
								if (bl_dec == '0) begin
									done = 1'b1;
									oc   = OC_EXHAUSTED;
								end else begin
									ph_n = PH_KIND;
								end
							end else begin
								ph_n = PH_SKIP;
							end
						end
					end
				end
				PH_SKIP: begin
					if (sk_e != '0) begin
						sk_n = sk_e - SK_W'(1);
					end
					if (bl_e != '0) begin
						bl_n = bl_dec;
					end
					if (bl_n == '0) begin
						done = 1'b1;
						oc   = OC_EXHAUSTED;
					end else if (sk_n == '0) begin
						ph_n = PH_KIND;
					end
				end
				PH_PACE: begin
					if (sk_e == '0) begin
						done = 1'b1;
						oc   = OC_FOUND;
						val  = opt_byte;
					end else begin
						sk_n = sk_e - SK_W'(1);
						if (bl_e != '0) begin
							bl_n = bl_dec;
						end
						if (bl_n == '0) begin
							done = 1'b1;
							oc   = OC_TRUNC;
						end
					end
				end
				default: begin
					ph_n = ph_e;
				end
			endcase
		end
		// walk over: back to idle
		if (done) begin
			ph_n = PH_IDLE;
			bl_n = '0;
			sk_n = '0;
		end
	end

	assign res.done    = done;
	assign res.outcome = oc;
	assign res.value   = val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			bl_q   <= '0;
			sk_q   <= '0;
			kind_q <= '0;
		end else if (step) begin
			ph_q   <= ph_n;
			bl_q   <= bl_n;
			sk_q   <= sk_n;
			kind_q <= kind_n;
		end
	end

endmodule

`default_nettype wire

// ----- src/tope_result.sv -----
// Result stage: delay-to-cycles product with saturation and the output register.
`default_nettype none

module tope_result (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  tope_pkg::walk_res_t res,
	input  wire  [10:0]         cycles_per_us,
	output logic                free,
	tope_result_if.source       result_ch
);
	import tope_pkg::*;

	logic              valid_q;
	outcome_t          oc_q;
	logic              found_q;
	logic [7:0]        value_q;
	logic [CYC_W-1:0]  cyc_q;
	logic [PROD_W-1:0] prod;
	logic              hit;

	assign hit  = (res.outcome == OC_FOUND);
	assign prod = PROD_W'(res.value) * PROD_W'(cycles_per_us);
	assign free = !valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oc_q    <= res.outcome;
			found_q <= hit;
			value_q <= hit ? res.value : 8'd0;
			if (!hit) begin
				cyc_q <= '0;
			end else if (prod[PROD_W-1]) begin
				cyc_q <= '1;
			end else begin
				cyc_q <= prod[CYC_W-1:0];
			end
		end
	end

	assign result_ch.valid       = valid_q;
	assign result_ch.outcome     = oc_q;
	assign result_ch.found       = found_q;
	assign result_ch.pace_value  = value_q;
	assign result_ch.pace_cycles = cyc_q;

endmodule

`default_nettype wire

// ----- bench/tcp_option_pace_extractor_tb.sv -----
// Self-checking bench for the TCP pacing-option extractor: option walks, config sweeps, stalls.

module tcp_option_pace_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tope_pkg::*;

	localparam int          HALF_PERIOD  = 5;
	localparam int          STALL_LIMIT  = 2000;  // cycles with no beat on either channel
	localparam int          CHUNK_BYTES  = 172;   // byte beats per random phase
	localparam int          CHUNKS       = 8;
	localparam int          SETTLE       = 4;     // pipeline depth plus margin
	localparam int          MAX_PRINTS   = 40;
	localparam logic [7:0]  OPT_EOL      = 8'd0;
	localparam logic [7:0]  OPT_NOP      = 8'd1;
	localparam int unsigned CYC_SAT      = (1 << CYC_W) - 1;

	// Register settings per random phase; the last one is drawn at random.
	localparam logic [7:0]  KIND_SET [CHUNKS] = '{8'd30, 8'd255, 8'd2, 8'd0,
		8'd1, 8'd76, 8'd253, 8'd128};
	localparam logic [10:0] CYC_SET  [CHUNKS] = '{11'd1, 11'd1024, 11'd2047, 11'd633,
		11'd1024, 11'd0, 11'd2047, 11'd999};

	typedef struct {
		outcome_t          outcome;
		logic              found;
		logic [7:0]        value;
		logic [CYC_W-1:0]  cycles;
	} pace_result_t;

	// Walks the option area byte by byte and queues the result each walk ends with.
	class pace_walk_model;
		logic [7:0]   pace_kind;
		logic [10:0]  cyc_per_us;
		phase_t       phase;
		int           left;
		int           skip;
		logic [7:0]   kind;
		pace_result_t due_results[$];
		int unsigned  mismatches;
		int unsigned  beats_taken;

		function new();
			pace_kind   = PACE_KIND_RST;
			cyc_per_us  = CYC_PER_US_RST;
			phase       = PH_IDLE;
			left        = 0;
			skip        = 0;
			kind        = 8'd0;
			mismatches  = 0;
			beats_taken = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void set_reg(cfg_idx_t idx, logic [10:0] val);
			case (idx)
				CFG_PACE_KIND:  pace_kind = val[7:0];
				CFG_CYC_PER_US: cyc_per_us = val;
				default: ;
			endcase
		endfunction

		function void close_walk(outcome_t oc, logic [7:0] v);
			pace_result_t r;
			int unsigned  prod;
			prod      = v * cyc_per_us;
			r.outcome = oc;
			r.found   = (oc == OC_FOUND);
			r.value   = r.found ? v : 8'd0;
			r.cycles  = !r.found ? '0 : (prod > CYC_SAT) ? CYC_SAT[CYC_W-1:0] : prod[CYC_W-1:0];
			due_results.push_back(r);
			phase = PH_IDLE;
			left  = 0;
			skip  = 0;
		endfunction

		function void take_byte(logic [7:0] b, logic first, logic [3:0] off);
			int len;
			beats_taken++;
			if (first) begin
				len = (off > HDR_BASE_WORDS) ? (int'(off) - int'(HDR_BASE_WORDS)) * 4 : 0;
				if (len > MAX_OPTION_BYTES)
					len = MAX_OPTION_BYTES;
				if (len == 0) begin
					close_walk(OC_NOOPT, 8'd0);
					return;
				end
				left  = len;
				skip  = 0;
				phase = PH_KIND;
			end
			case (phase)
				PH_KIND: begin
					if (b == OPT_EOL) begin
						close_walk(OC_EOL, 8'd0);
					end else if (b == OPT_NOP) begin
						left--;
						if (left == 0)
							close_walk(OC_EXHAUSTED, 8'd0);
					end else if (left < 2) begin
						close_walk(OC_TRUNC, 8'd0);
					end else begin
						kind  = b;
						left--;
						phase = PH_SIZE;
					end
				end
				PH_SIZE: begin
					if (b < 2) begin
						close_walk(OC_SILLY, 8'd0);
					end else if (b > left + 1) begin
						close_walk(OC_PARTIAL, 8'd0);
					end else begin
						left--;
						if (kind == pace_kind) begin
							// delay sits after two skipped bytes, whatever the size says
							if (left == 0) begin
								close_walk(OC_TRUNC, 8'd0);
							end else begin
								skip  = PACE_SKIP_BYTES;
								phase = PH_PACE;
							end
						end else begin
							skip = b - 2;
							if (skip != 0)
								phase = PH_SKIP;
							else if (left == 0)
								close_walk(OC_EXHAUSTED, 8'd0);
							else
								phase = PH_KIND;
						end
					end
				end
				PH_SKIP: begin
					if (skip > 0)
						skip--;
					if (left > 0)
						left--;
					if (left == 0)
						close_walk(OC_EXHAUSTED, 8'd0);
					else if (skip == 0)
						phase = PH_KIND;
				end
				PH_PACE: begin
					if (skip == 0) begin
						close_walk(OC_FOUND, b);
					end else begin
						skip--;
						if (left > 0)
							left--;
						if (left == 0)
							close_walk(OC_TRUNC, 8'd0);
					end
				end
				default: ;  // idle: stray byte, ignored
			endcase
		endfunction

		task report_mismatch(string msg);
			if (mismatches < MAX_PRINTS)
				$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task match_result(logic [2:0] oc, logic found, logic [7:0] value,
				logic [CYC_W-1:0] cycles);
			pace_result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result beat with none due (outcome %0d)", oc));
				return;
			end
			want = due_results.pop_front();
			if (oc !== want.outcome)
				report_mismatch($sformatf("outcome %0d, want %s", oc, want.outcome.name()));
			if (found !== want.found)
				report_mismatch($sformatf("found %0b, want %0b", found, want.found));
			if (value !== want.value)
				report_mismatch($sformatf("pace_value %0d, want %0d", value, want.value));
			if (cycles !== want.cycles)
				report_mismatch($sformatf("pace_cycles %0d, want %0d", cycles, want.cycles));
		endtask
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_we;
	cfg_idx_t       cfg_index;
	logic [10:0]    cfg_wdata;
	int             send_idle_pct;
	int             stall_pct;
	int             quiet_cycles;
	pace_walk_model walk_model;

	tope_byte_if   byte_ch ();
	tope_result_if result_ch ();

	tcp_option_pace_extractor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Receiver: per-cycle random stall at the rate of the current phase.
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Beat monitor: feed the model on byte beats, check on result beats.
	// Sampled at the edge, so both channels see pre-edge values.
	always @(posedge clk) begin
		if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
			walk_model.take_byte(byte_ch.opt_byte, byte_ch.first_byte, byte_ch.data_offset);
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			walk_model.match_result(result_ch.outcome, result_ch.found, result_ch.pace_value,
				result_ch.pace_cycles);
	end

	// Watchdog: too long without a beat on either channel means a hang.
	always @(posedge clk) begin
		if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
				(result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tcp_option_pace_extractor test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// One byte beat. valid stays high into the next beat unless the sender
	// decides to idle first, so it is never dropped and raised in one step.
	task automatic send_beat(input logic [7:0] b, input logic first, input logic [3:0] off);
		if ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.opt_byte    <= b;
		byte_ch.first_byte  <= first;
		byte_ch.data_offset <= off;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
	endtask

	// Option area of one packet; data_offset on later beats is don't-care noise.
	task automatic send_walk(input logic [3:0] off, input logic [7:0] q[$]);
		foreach (q[i])
			send_beat(q[i], i == 0, (i == 0) ? off : 4'($urandom_range(15)));
	endtask

	// Stop sending and wait until every due result is out and the pipe is empty.
	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (walk_model.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Both registers back to back; only called with the block idle.
	task automatic write_regs(input logic [7:0] kind, input logic [10:0] cyc);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PACE_KIND;
		cfg_wdata <= {3'b000, kind};
		@(posedge clk);
		walk_model.set_reg(CFG_PACE_KIND, {3'b000, kind});
		cfg_index <= CFG_CYC_PER_US;
		cfg_wdata <= cyc;
		@(posedge clk);
		walk_model.set_reg(CFG_CYC_PER_US, cyc);
		cfg_we    <= 1'b0;
	endtask

	// Mostly well-formed option list: NOPs, pace options, other options,
	// sometimes an end-of-list or a malformed size, cut to the area length.
	function automatic void build_walk(output logic [3:0] off, ref logic [7:0] q[$],
			input logic [7:0] pkind);
		int len;
		int room;
		int pick;
		int sz;
		off = 4'($urandom_range(15, 6));
		len = (int'(off) - int'(HDR_BASE_WORDS)) * 4;
		q.delete();
		while (q.size() < len) begin
			room = len - q.size();
			pick = $urandom_range(99);
			if (pick < 6) begin
				q.push_back(OPT_EOL);
				break;
			end else if (pick < 26) begin
				q.push_back(OPT_NOP);
			end else if (pick < 61) begin
				sz = (room >= 6) ? 6 : room;
				if ($urandom_range(3) == 0)
					sz = $urandom_range(room + 1, 0);
				q.push_back(pkind);
				q.push_back(8'(sz));
				q.push_back(rand_byte());
				q.push_back(rand_byte());
				q.push_back(rand_byte());
			end else begin
				sz = (room < 2) ? 2 : $urandom_range((room < 10) ? room : 10, 2);
				if ($urandom_range(19) == 0)
					sz = $urandom_range(255);
				q.push_back(8'($urandom_range(255, 2)));
				q.push_back(8'(sz));
				for (int i = 2; i < sz && q.size() < len; i++)
					q.push_back(rand_byte());
			end
		end
		while (q.size() > len)
			void'(q.pop_back());
	endfunction

	initial begin
		logic [3:0] off;
		logic [7:0] walk_q[$];
		int         pick;
		int         goal;
		logic [7:0] kind;
		logic [10:0] cyc;

		walk_model            = new();
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_PACE_KIND;
		cfg_wdata             = '0;
		byte_ch.valid         = 1'b0;
		byte_ch.opt_byte      = 8'h00;
		byte_ch.first_byte    = 1'b0;
		byte_ch.data_offset   = 4'h0;
		result_ch.ready       = 1'b0;
		send_idle_pct         = 0;
		stall_pct             = 0;
		quiet_cycles          = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walks with the reset registers, no idling.
		send_beat(8'hFF, 1'b0, 4'hF);                                   // stray byte while idle
		send_walk(4'd5, '{8'hAA});                                      // header without options
		send_walk(4'd7, '{PACE_KIND_RST, 8'd6, 8'h00, 8'h00, 8'hFF});   // pace found, max delay
		send_walk(4'd6, '{OPT_EOL});                                    // end of list
		send_walk(4'd6, '{OPT_NOP, OPT_NOP, OPT_NOP, 8'd7});            // kind with one byte left
		send_walk(4'd15, '{8'd9, 8'd1});                                // silly size, max offset
		send_walk(4'd6, '{8'd9, 8'd5});                                 // size past the area
		send_walk(4'd6, '{8'd9});                                       // dropped by restart
		send_walk(4'd7, '{PACE_KIND_RST, 8'd2, 8'hAB, 8'hCD, 8'h00});   // short pace option
		send_walk(4'd6, '{PACE_KIND_RST, 8'd4, 8'd1, 8'd2});            // area ends before delay
		drain_results();

		// Random phases: idling pattern cycles through none / sender / receiver / both,
		// registers change between phases with the block idle.
		for (int c = 0; c < CHUNKS; c++) begin
			kind = KIND_SET[c];
			cyc  = CYC_SET[c];
			if (c == CHUNKS - 1) begin
				kind = 8'($urandom_range(255));
				cyc  = 11'($urandom_range(1024, 1));
			end
			write_regs(kind, cyc);
			case (c % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 79; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 79; end
				default: begin send_idle_pct = 19; stall_pct = 19; end
			endcase
			goal = walk_model.beats_taken + CHUNK_BYTES;
			while (walk_model.beats_taken < goal) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					build_walk(off, walk_q, walk_model.pace_kind);
					// some walks are cut short so the next packet restarts them
					if (pick >= 63 && walk_q.size() > 1)
						repeat ($urandom_range(walk_q.size() - 1, 1)) void'(walk_q.pop_back());
					send_walk(off, walk_q);
				end else if (pick < 92) begin
					walk_q.delete();
					repeat ($urandom_range(12, 1)) walk_q.push_back(rand_byte());
					send_walk(4'($urandom_range(15)), walk_q);
				end else begin
					repeat ($urandom_range(3, 1))
						send_beat(rand_byte(), 1'b0, 4'($urandom_range(15)));
				end
			end
			drain_results();
		end

		repeat (2 * SETTLE) @(posedge clk);
		if (walk_model.mismatches == 0 && walk_model.pending() == 0)
			$display("tcp_option_pace_extractor test passed");
		else
			$display("tcp_option_pace_extractor test failed");
		$finish;
	end

endmodule
